[design/dd97_pkg.sv]
// ============================================================================
// dd97_pkg
// Shared types, constants and helpers for the DD 9/7 forward row lifting block.
// ============================================================================
package dd97_pkg;

   localparam int SAMPLE_IN_W      = 10;
   localparam int SAMPLE_W         = 11;
   localparam int COEF_W           = 13;
   localparam int CSR_W            = 12;
   localparam int MIN_ROW_PAIRS    = 8;
   localparam int ROW_PAIRS_RESET  = 960;
   localparam int SAMPLE_OFFSET    = 512;
   localparam int FIRST_EMIT_INDEX = 2;
   localparam int RESULT_SLOTS     = 3;
   localparam int SLOT_CNT_W       = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FIRST,
      KIND_ONE,
      KIND_FLUSH
   } kind_type;

   typedef struct packed {
      logic     row_end;
      coef_type low_coef;
      coef_type high_coef;
   } result_type;

   typedef struct packed {
      logic                  valid;
      logic [SLOT_CNT_W-1:0] count;
   } rsp_load_type;

   typedef struct packed {
      kind_type   kind;
      sample_type w0;
      sample_type w1;
      sample_type w2;
      sample_type en;
      sample_type od0;
      sample_type od1;
      sample_type on;
   } stage_type;

   // (v - 512) * 2, wraps into 11 bits exactly
   function automatic sample_type conv_sample(input logic [SAMPLE_IN_W-1:0] v);
      logic [SAMPLE_W-1:0] t;
      t = {v, 1'b0} - SAMPLE_W'(SAMPLE_OFFSET * 2);
      return sample_type'(t);
   endfunction

endpackage

[design/dd97_lift.sv]
// ============================================================================
// dd97_lift
// One lifting lane: predict step for the highpass, update step for the lowpass.
// ============================================================================
module dd97_lift (
   input  dd97_pkg::sample_type a,
   input  dd97_pkg::sample_type b,
   input  dd97_pkg::sample_type c,
   input  dd97_pkg::sample_type d,
   input  dd97_pkg::sample_type odd,
   input  dd97_pkg::coef_type   hp_in,
   input  logic                 hp_own,
   output dd97_pkg::coef_type   high,
   output dd97_pkg::coef_type   low
);

   logic signed [15:0] a_x, b_x, c_x, d_x, pred_sum, pred, high_full;
   logic signed [14:0] upd_sum, l_full;
   dd97_pkg::coef_type hp;

   always_comb begin
      a_x       = 16'(a);
      b_x       = 16'(b);
      c_x       = 16'(c);
      d_x       = 16'(d);
      pred_sum  = (b_x <<< 3) + b_x + (c_x <<< 3) + c_x - a_x - d_x + 16'sd8;
      pred      = pred_sum >>> 4;
      high_full = 16'(odd) - pred;
      high      = dd97_pkg::coef_type'(high_full[dd97_pkg::COEF_W-1:0]);
      hp        = hp_own ? high : hp_in;
      upd_sum   = 15'(hp) + 15'(high) + 15'sd2;
      l_full    = 15'(b) + (upd_sum >>> 2);
      low       = dd97_pkg::coef_type'(l_full[dd97_pkg::COEF_W-1:0]);
   end

endmodule

[design/dd97_rsp_buf.sv]
// ============================================================================
// dd97_rsp_buf
// Three-slot result buffer: loads one or three results, drains one per transfer.
// ============================================================================
module dd97_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  dd97_pkg::rsp_load_type ld,
   input  dd97_pkg::result_type   ld_data [dd97_pkg::RESULT_SLOTS],
   output logic                   can_load,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output dd97_pkg::result_type   rsp_head
);

   dd97_pkg::result_type q_ff [dd97_pkg::RESULT_SLOTS];
   dd97_pkg::result_type q_in [dd97_pkg::RESULT_SLOTS];
   logic [dd97_pkg::SLOT_CNT_W-1:0] count_ff, count_in;
   logic pop;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_head   = q_ff[0];
   assign pop        = rsp_tvalid && rsp_tready;
   assign can_load   = (count_ff == '0) || ((count_ff == 2'd1) && pop);

   always_comb begin
      q_in     = q_ff;
      count_in = count_ff;
      if (ld.valid) begin
         q_in     = ld_data;
         count_in = ld.count;
      end else if (pop) begin
         q_in[0]  = q_ff[1];
         q_in[1]  = q_ff[2];
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

[design/dd97_forward_row_lifting_10bit.sv]
// ============================================================================
// dd97_forward_row_lifting_10bit
// Forward DD 9/7 lifting wavelet over one row, streamed as even/odd pairs.
// ============================================================================
// Output path: the pair that completes a coefficient pair is held in the stage
// register, then in the result buffer; a row's last pair loads three at once.
// Throughput: one pair per cycle; the two silent pairs that start the next row
// cover the flush drain, so the input only stalls while the result side stalls.
// Reset: synchronous; clears the row position, sample window and buffers,
// and sets row_pairs to 960.
module dd97_forward_row_lifting_10bit #(
   parameter int MAX_ROW_PAIRS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // even_sample[9:0], odd_sample[19:10], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // low_coef[12:0], high_coef[25:13], zero pad
   output logic        rsp_tlast,   // row_end
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data  // row_pairs
);

   localparam int IW = $clog2(MAX_ROW_PAIRS);
   localparam int NW = $clog2(MAX_ROW_PAIRS + 1);
   localparam int CW = (NW > dd97_pkg::CSR_W) ? NW : dd97_pkg::CSR_W;

   logic [dd97_pkg::CSR_W-1:0] row_pairs_ff;
   logic [IW-1:0]              pair_index_ff, pair_index_in;
   dd97_pkg::sample_type       win_ff [3];
   dd97_pkg::sample_type       odd_ff [2];
   dd97_pkg::coef_type         prev_high_ff, prev_high_in;
   logic                       stg_valid_ff, stg_valid_in;
   dd97_pkg::stage_type        stg_ff, stg_in;

   logic [CW-1:0]        rp, n_lim, k_x;
   logic                 accept, is_last, stg_emits, stg_move, can_load;
   dd97_pkg::sample_type en, on;
   dd97_pkg::kind_type   kind;

   dd97_pkg::coef_type     h0, h1, h2, l0, l1, l2;
   dd97_pkg::rsp_load_type ld;
   dd97_pkg::result_type   ld_data [dd97_pkg::RESULT_SLOTS];
   dd97_pkg::result_type   rsp_head;

   // row position and pair classification
   always_comb begin
      rp = CW'(row_pairs_ff);
      if (rp < CW'(dd97_pkg::MIN_ROW_PAIRS)) begin
         n_lim = CW'(dd97_pkg::MIN_ROW_PAIRS);
      end else if (rp > CW'(MAX_ROW_PAIRS)) begin
         n_lim = CW'(MAX_ROW_PAIRS);
      end else begin
         n_lim = rp;
      end
      k_x     = CW'(pair_index_ff);
      is_last = (k_x >= n_lim - CW'(1));
      if (is_last) begin
         kind          = dd97_pkg::KIND_FLUSH;
         pair_index_in = '0;
      end else begin
         if (pair_index_ff == IW'(dd97_pkg::FIRST_EMIT_INDEX)) begin
            kind = dd97_pkg::KIND_FIRST;
         end else if (pair_index_ff > IW'(dd97_pkg::FIRST_EMIT_INDEX)) begin
            kind = dd97_pkg::KIND_ONE;
         end else begin
            kind = dd97_pkg::KIND_NONE;
         end
         pair_index_in = pair_index_ff + IW'(1);
      end
   end

   assign en = dd97_pkg::conv_sample(req_tdata[9:0]);
   assign on = dd97_pkg::conv_sample(req_tdata[19:10]);

   // handshake and stage control
   assign stg_emits  = (stg_ff.kind != dd97_pkg::KIND_NONE);
   assign stg_move   = stg_valid_ff && (!stg_emits || can_load);
   assign req_tready = !stg_valid_ff || stg_move;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      stg_in.kind = kind;
      stg_in.w0   = win_ff[0];
      stg_in.w1   = win_ff[1];
      stg_in.w2   = win_ff[2];
      stg_in.en   = en;
      stg_in.od0  = odd_ff[0];
      stg_in.od1  = odd_ff[1];
      stg_in.on   = on;
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (stg_move) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
   end

   // three lifting lanes; lane 0 alone serves a single result
   dd97_lift u_lane0 (
      .a      ((stg_ff.kind == dd97_pkg::KIND_FIRST) ? stg_ff.w1 : stg_ff.w0),
      .b      (stg_ff.w1),
      .c      (stg_ff.w2),
      .d      (stg_ff.en),
      .odd    (stg_ff.od0),
      .hp_in  (prev_high_ff),
      .hp_own (stg_ff.kind == dd97_pkg::KIND_FIRST),
      .high   (h0),
      .low    (l0)
   );

   dd97_lift u_lane1 (
      .a      (stg_ff.w1),
      .b      (stg_ff.w2),
      .c      (stg_ff.en),
      .d      (stg_ff.en),
      .odd    (stg_ff.od1),
      .hp_in  (h0),
      .hp_own (1'b0),
      .high   (h1),
      .low    (l1)
   );

   dd97_lift u_lane2 (
      .a      (stg_ff.w2),
      .b      (stg_ff.en),
      .c      (stg_ff.en),
      .d      (stg_ff.w2),
      .odd    (stg_ff.on),
      .hp_in  (h1),
      .hp_own (1'b0),
      .high   (h2),
      .low    (l2)
   );

   always_comb begin
      ld.valid   = stg_move && stg_emits;
      ld.count   = (stg_ff.kind == dd97_pkg::KIND_FLUSH) ? 2'd3 : 2'd1;
      ld_data[0] = '{row_end: 1'b0, low_coef: l0, high_coef: h0};
      ld_data[1] = '{row_end: 1'b0, low_coef: l1, high_coef: h1};
      ld_data[2] = '{row_end: 1'b1, low_coef: l2, high_coef: h2};
      prev_high_in = prev_high_ff;
      if (ld.valid) begin
         prev_high_in = (stg_ff.kind == dd97_pkg::KIND_FLUSH) ? h2 : h0;
      end
   end

   dd97_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .ld         (ld),
      .ld_data    (ld_data),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_head   (rsp_head)
   );

   assign rsp_tdata = {6'd0, rsp_head.high_coef, rsp_head.low_coef};
   assign rsp_tlast = rsp_head.row_end;

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff <= stg_in;
      end
      if (reset) begin
         row_pairs_ff  <= dd97_pkg::CSR_W'(dd97_pkg::ROW_PAIRS_RESET);
         pair_index_ff <= '0;
         win_ff        <= '{default: '0};
         odd_ff        <= '{default: '0};
         prev_high_ff  <= '0;
         stg_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            row_pairs_ff <= csr_wr_data;
         end
         if (accept) begin
            pair_index_ff <= pair_index_in;
            win_ff[0]     <= win_ff[1];
            win_ff[1]     <= win_ff[2];
            win_ff[2]     <= en;
            odd_ff[0]     <= odd_ff[1];
            odd_ff[1]     <= on;
         end
         prev_high_ff <= prev_high_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_only_when_room: assert property (@(posedge clock) disable iff (reset)
      ld.valid |-> can_load)
      else $error("result buffer loaded while still holding results");

   a_flush_restarts_row: assert property (@(posedge clock) disable iff (reset)
      (accept && is_last) |=> (pair_index_ff == '0))
      else $error("row position not cleared after the last pair");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> stg_valid_ff)
      else $error("accepted transfer did not reach the stage register");
`endif

endmodule
